@@ rtl/core/nbd_pkg.sv @@
// ----------------------------------------------------------------------------
// nbd_pkg
// Shared types, codes and the popcount helper for the binary descriptor
// nearest-neighbour search.
// ----------------------------------------------------------------------------
`default_nettype none

package nbd_pkg;

  localparam int unsigned DESC_WORDS = 4;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned DIST_W     = 9;
  localparam int unsigned PCNT_W     = 7;
  localparam int unsigned ID_LIMIT   = 1024;

  localparam logic [DIST_W-1:0] NO_MATCH_DIST = 9'd257;

  // func codes on the input channel
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_CAND   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CAND   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [WORD_W-1:0] desc_word_0;
    logic [WORD_W-1:0] desc_word_1;
    logic [WORD_W-1:0] desc_word_2;
    logic [WORD_W-1:0] desc_word_3;
    logic              desc_valid;
    logic [ID_W-1:0]   cand_id;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   best_index;
    logic [DIST_W-1:0] best_distance;
  } res_t;

  // one queued operation for the back end
  typedef struct packed {
    op_t                              op;
    logic [DESC_WORDS-1:0][PCNT_W-1:0] pcnt;
    logic [ID_W-1:0]                  id;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  // adder tree, six levels of independent narrow adds
  function automatic logic [PCNT_W-1:0] popcount64(input logic [WORD_W-1:0] v);
    logic [31:0][1:0] l1;
    logic [15:0][2:0] l2;
    logic [7:0][3:0]  l3;
    logic [3:0][4:0]  l4;
    logic [1:0][5:0]  l5;
    for (int i = 0; i < 32; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    end
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/nearest_binary_descriptor_core.sv @@
// ----------------------------------------------------------------------------
// nearest_binary_descriptor_core
// Throughput: one transaction per cycle while the queue has room; the front
//   popcount is combinational and the back end pops the head unless a
//   finish is held, so the queue only fills while the result is stalled.
// Result path: an accepted finish is queued, then loads the result register.
// Reset: synchronous, active low; clears the query flag, the running best
//   (distance 257, no match), the queue and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_binary_descriptor_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire nbd_pkg::req_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output nbd_pkg::res_t       out_data
);

  nbd_pkg::push_t  q_push;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  nbd_pkg::entry_t head;

  nbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  nbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_push     (q_push),
    .q_full     (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  nbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/nbd_front.sv @@
// ----------------------------------------------------------------------------
// nbd_front
// Accepts input transactions, holds the query, classifies each item and
// forms the per-word distance counts for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nbd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire nbd_pkg::req_t  in_data,
  input  wire logic           q_full,
  output nbd_pkg::push_t      q_push
);

  logic [nbd_pkg::DESC_WORDS-1:0][nbd_pkg::WORD_W-1:0] query_r;
  logic [nbd_pkg::DESC_WORDS-1:0][nbd_pkg::WORD_W-1:0] query_nxt;
  logic                                                query_ok_r;
  logic                                                query_ok_nxt;
  logic [nbd_pkg::DESC_WORDS-1:0][nbd_pkg::WORD_W-1:0] cand_w;
  logic                                                accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cand_w   = {in_data.desc_word_3, in_data.desc_word_2,
                     in_data.desc_word_1, in_data.desc_word_0};

  always_comb begin
    query_nxt    = query_r;
    query_ok_nxt = query_ok_r;
    if (accept && in_data.func == nbd_pkg::FUNC_LOAD) begin
      query_nxt    = cand_w;
      query_ok_nxt = in_data.desc_valid;
    end
  end

  always_comb begin
    for (int k = 0; k < nbd_pkg::DESC_WORDS; k++) begin
      q_push.entry.pcnt[k] = nbd_pkg::popcount64(query_r[k] ^ cand_w[k]);
    end
    q_push.entry.id = nbd_pkg::ID_W'(32'(in_data.cand_id) % nbd_pkg::ID_LIMIT);
    case (in_data.func)
      nbd_pkg::FUNC_LOAD: begin
        q_push.push     = accept;
        q_push.entry.op = nbd_pkg::OP_LOAD;
      end
      nbd_pkg::FUNC_CAND: begin
        // dropped here when either side is invalid
        q_push.push     = accept && in_data.desc_valid && query_ok_r;
        q_push.entry.op = nbd_pkg::OP_CAND;
      end
      nbd_pkg::FUNC_FINISH: begin
        q_push.push     = accept;
        q_push.entry.op = nbd_pkg::OP_FINISH;
      end
      default: begin
        q_push.push     = 1'b0;
        q_push.entry.op = nbd_pkg::OP_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    query_r <= query_nxt;
    if (!rst_n) begin
      query_ok_r <= 1'b0;
    end else begin
      query_ok_r <= query_ok_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nbd_queue.sv @@
// ----------------------------------------------------------------------------
// nbd_queue
// Short FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module nbd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire nbd_pkg::push_t  q_push,
  output logic                 q_full,
  input  wire logic            pop,
  output logic                 head_valid,
  output nbd_pkg::entry_t      head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  nbd_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_full     = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = q_push.push && !q_full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nbd_back.sv @@
// ----------------------------------------------------------------------------
// nbd_back
// Sums the word counts, keeps the running best (cleared on load) and drives
// the result register on finish.
// ----------------------------------------------------------------------------
`default_nettype none

module nbd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire nbd_pkg::entry_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output nbd_pkg::res_t         out_data
);

  logic [nbd_pkg::DIST_W-1:0] best_dist_r;
  logic [nbd_pkg::DIST_W-1:0] best_dist_nxt;
  logic [nbd_pkg::ID_W-1:0]   best_id_r;
  logic [nbd_pkg::ID_W-1:0]   best_id_nxt;
  logic                       have_match_r;
  logic                       have_match_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  nbd_pkg::res_t              out_data_r;
  nbd_pkg::res_t              out_data_nxt;
  logic [nbd_pkg::DIST_W-1:0] cand_dist;

  assign cand_dist = nbd_pkg::DIST_W'(head.pcnt[0]) + nbd_pkg::DIST_W'(head.pcnt[1])
                   + nbd_pkg::DIST_W'(head.pcnt[2]) + nbd_pkg::DIST_W'(head.pcnt[3]);

  // a finish waits only while the result register is still held
  assign pop = head_valid && (head.op != nbd_pkg::OP_FINISH || !out_valid_r || out_ready);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    best_dist_nxt  = best_dist_r;
    best_id_nxt    = best_id_r;
    have_match_nxt = have_match_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    if (pop) begin
      case (head.op)
        nbd_pkg::OP_LOAD: begin
          best_dist_nxt  = nbd_pkg::NO_MATCH_DIST;
          best_id_nxt    = '0;
          have_match_nxt = 1'b0;
        end
        nbd_pkg::OP_CAND: begin
          // strict compare: ties keep the earlier candidate
          if (cand_dist < best_dist_r) begin
            best_dist_nxt  = cand_dist;
            best_id_nxt    = head.id;
            have_match_nxt = 1'b1;
          end
        end
        nbd_pkg::OP_FINISH: begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.found         = have_match_r;
          out_data_nxt.best_index    = have_match_r ? best_id_r : '0;
          out_data_nxt.best_distance = best_dist_r;
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      best_dist_r  <= nbd_pkg::NO_MATCH_DIST;
      best_id_r    <= '0;
      have_match_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      best_dist_r  <= best_dist_nxt;
      best_id_r    <= best_id_nxt;
      have_match_r <= have_match_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nbd_checker.sv @@
// ----------------------------------------------------------------------------
// nbd_checker
// Port-level checks, mostly on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module nbd_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire nbd_pkg::res_t out_data
);

  // a held result transaction must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.best_distance == nbd_pkg::NO_MATCH_DIST && out_data.best_index == '0)
    else $error("empty search result not cleared");

  a_match_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.best_distance < nbd_pkg::NO_MATCH_DIST)
    else $error("match distance out of range");

  // a finish cannot appear at the output before it has passed the queue
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(in_valid && in_ready, 2) || $past(out_valid, 2)
      || $past(!in_ready, 2) || $past(in_valid && in_ready, 3) || !$past(rst_n, 3))
    else $error("result without a preceding finish");

endmodule

bind nearest_binary_descriptor_core nbd_checker u_nbd_checker (.*);

`default_nettype wire
